// ===== rtl/color_key_layer_compositor_top_defines.svh =====
// assertion macros for the layer compositor
`ifndef COLOR_KEY_LAYER_COMPOSITOR_TOP_DEFINES_SVH
`define COLOR_KEY_LAYER_COMPOSITOR_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define CKL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("compositor check failed: same-cycle implication");

// condition must never hold, off during reset
`define CKL_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("compositor check failed: forbidden condition");

`endif

// ===== rtl/ckl_pkg.sv =====
package ckl_pkg;

  // default image size in pixels
  localparam int PIXELS_DEF = 65536;
  // highest number of layers the page can hold
  localparam int MAX_LAYERS = 32;

  // command codes
  typedef enum logic [1:0] {
    OP_COMPOSE = 2'd0,
    OP_DEPTH   = 2'd1,
    OP_READ    = 2'd2
  } ckl_op_t;

  // register indexes on the config port
  typedef enum logic [1:0] {
    REG_VISIBLE     = 2'd0,
    REG_TRANSPARENT = 2'd1,
    REG_ACTIVE      = 2'd2,
    REG_COUNT       = 2'd3
  } ckl_reg_t;

  // clearing sweep after reset, then normal running
  typedef enum logic {
    MODE_CLEAR,
    MODE_RUN
  } ckl_mode_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [4:0]  layer;
    logic [15:0] pixel_index;
    logic [7:0]  color;
  } ckl_cmd_t;

  typedef struct packed {
    logic [7:0] pixel_color;
    logic [4:0] pixel_layer;
  } ckl_result_t;

  typedef struct packed {
    logic [31:0] visible_layers;
    logic [7:0]  key_index;
    logic [4:0]  active_layer;
    logic [5:0]  layer_count;
  } ckl_cfg_t;

  // write enables toward the two stores
  typedef struct packed {
    logic color_we;
    logic depth_we;
  } ckl_wr_t;

endpackage

// ===== rtl/ckl_ram.sv =====
module ckl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/ckl_regs.sv =====
module ckl_regs (
  input  logic            clk,
  input  logic            rst,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [3:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  output ckl_pkg::ckl_cfg_t cfg
);
  import ckl_pkg::*;

  ckl_reg_t sel;
  logic     wr_beat;

  assign sel     = ckl_reg_t'(paddr[3:2]);
  assign wr_beat = psel && penable && pwrite;
  assign pready  = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.visible_layers <= 32'd1;
      cfg.key_index      <= 8'd0;
      cfg.active_layer   <= 5'd0;
      cfg.layer_count    <= 6'd1;
    end else if (wr_beat) begin
      case (sel)
        REG_VISIBLE:     cfg.visible_layers <= pwdata;
        REG_TRANSPARENT: cfg.key_index      <= pwdata[7:0];
        REG_ACTIVE:      cfg.active_layer   <= pwdata[4:0];
        REG_COUNT:       cfg.layer_count    <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (sel)
      REG_VISIBLE:     prdata = cfg.visible_layers;
      REG_TRANSPARENT: prdata = {24'd0, cfg.key_index};
      REG_ACTIVE:      prdata = {27'd0, cfg.active_layer};
      REG_COUNT:       prdata = {26'd0, cfg.layer_count};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/ckl_ctrl.sv =====
module ckl_ctrl #(
  parameter int PIXELS = ckl_pkg::PIXELS_DEF,
  localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  ckl_pkg::ckl_cmd_t    cmd,
  input  ckl_pkg::ckl_cfg_t    cfg,
  output logic                 busy,
  output logic [AW-1:0]        mem_addr,
  output ckl_pkg::ckl_wr_t     wr,
  output logic [7:0]           color_wdata,
  output logic [4:0]           depth_wdata,
  input  logic [7:0]           color_rdata,
  input  logic [4:0]           depth_rdata,
  output logic                 result_valid,
  output ckl_pkg::ckl_result_t result
);
  import ckl_pkg::*;

  localparam logic [AW-1:0] LAST_ADDR = AW'(PIXELS - 1);

  ckl_mode_t   mode, mode_next;
  logic [AW-1:0] clear_addr, clear_addr_next;
  logic        accept;
  logic        in_range;
  logic [5:0]  count_eff;
  logic [31:0] below, part, lowbit, layer_bit;
  logic        takes_part, base, opaque, depth_ok, ok;
  logic        range_ok;

  assign busy   = (mode == MODE_CLEAR);
  assign accept = start && !busy;
  assign in_range = 32'(cmd.pixel_index) < 32'(PIXELS);

  // mask of the layers that take part and the base layer
  always_comb begin
    count_eff = (32'(cfg.layer_count) > 32'(MAX_LAYERS)) ? 6'(MAX_LAYERS)
                                                          : cfg.layer_count;
    below      = (count_eff >= 6'd32) ? '1 : ((32'd1 << count_eff) - 32'd1);
    part       = cfg.visible_layers & below;
    lowbit     = part & (~part + 32'd1);
    layer_bit  = 32'd1 << cmd.layer;
    takes_part = part[cmd.layer];
    base       = (lowbit == layer_bit);
    opaque     = (cmd.color != cfg.key_index);
    depth_ok   = base || (opaque && (cmd.layer != cfg.active_layer));
    ok         = accept && in_range && takes_part;
  end

  // clearing sweep and write decode
  always_comb begin
    mode_next       = mode;
    clear_addr_next = clear_addr;
    wr              = '0;
    mem_addr        = AW'(cmd.pixel_index);
    color_wdata     = cmd.color;
    depth_wdata     = cmd.layer;
    case (mode)
      MODE_CLEAR: begin
        wr.color_we     = 1'b1;
        wr.depth_we     = 1'b1;
        mem_addr        = clear_addr;
        color_wdata     = 8'd0;
        depth_wdata     = 5'd0;
        clear_addr_next = clear_addr + AW'(1);
        if (clear_addr == LAST_ADDR) begin
          mode_next = MODE_RUN;
        end
      end
      MODE_RUN: begin
        case (cmd.op)
          OP_COMPOSE: begin
            wr.color_we = ok && (base || opaque);
            wr.depth_we = ok && depth_ok;
          end
          OP_DEPTH: begin
            wr.depth_we = ok && depth_ok;
          end
          default: ;
        endcase
      end
      default: mode_next = MODE_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_CLEAR;
      clear_addr <= '0;
    end else begin
      mode       <= mode_next;
      clear_addr <= clear_addr_next;
    end
  end

  // read beat comes out in the cycle after accept
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= accept && (cmd.op == OP_READ);
    end
    range_ok <= in_range;
  end

  assign result.pixel_color = range_ok ? color_rdata : 8'd0;
  assign result.pixel_layer = range_ok ? depth_rdata : 5'd0;

endmodule

// ===== rtl/color_key_layer_compositor_top.sv =====
// color-key layer compositor with a depth map
// command channel: cmd is taken at a rising edge with start high and busy low;
//   ops are compose pixel, depth-only rebuild pixel and read pixel
// result channel: result_valid strobes for one cycle with result holding the
//   flattened color and depth entry of a read; only reads give a beat
// read timing: a read beat appears in the cycle after its command is taken
// throughput: one command per non-busy cycle, set by each store's single port
//   (compose and rebuild are blind writes, a read is one registered read)
// config: APB registers at byte addresses 0 visible_layers, 4 key_index,
//   8 active_layer, 12 layer_count; pready is always high
// reset: rst is synchronous; registers take their reset values and a clearing
//   pass then zeroes both stores one pixel a cycle, with busy high; config
//   writes are taken during the pass
// the receiver cannot stall: each result beat lasts exactly one cycle
module color_key_layer_compositor_top #(
  parameter int PIXELS = ckl_pkg::PIXELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  ckl_pkg::ckl_cmd_t    cmd,
  output logic                 busy,
  output logic                 result_valid,
  output ckl_pkg::ckl_result_t result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import ckl_pkg::*;
  `include "color_key_layer_compositor_top_defines.svh"

  localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;

  ckl_cfg_t      cfg;
  ckl_wr_t       wr;
  logic [AW-1:0] mem_addr;
  logic [7:0]    color_wdata, color_rdata;
  logic [4:0]    depth_wdata, depth_rdata;

  ckl_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ckl_ctrl #(.PIXELS(PIXELS)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .cmd          (cmd),
    .cfg          (cfg),
    .busy         (busy),
    .mem_addr     (mem_addr),
    .wr           (wr),
    .color_wdata  (color_wdata),
    .depth_wdata  (depth_wdata),
    .color_rdata  (color_rdata),
    .depth_rdata  (depth_rdata),
    .result_valid (result_valid),
    .result       (result)
  );

  // flattened image store
  ckl_ram #(.WIDTH(8), .DEPTH(PIXELS)) u_flat_ram (
    .clk   (clk),
    .we    (wr.color_we),
    .addr  (mem_addr),
    .wdata (color_wdata),
    .rdata (color_rdata)
  );

  // depth map store
  ckl_ram #(.WIDTH(5), .DEPTH(PIXELS)) u_depth_ram (
    .clk   (clk),
    .we    (wr.depth_we),
    .addr  (mem_addr),
    .wdata (depth_wdata),
    .rdata (depth_rdata)
  );

  // checks
  `CKL_ASSERT_IMP(a_write_needs_cmd, !busy && (wr.color_we || wr.depth_we), start)
  `CKL_ASSERT_IMP(a_color_only_compose, !busy && wr.color_we, cmd.op == OP_COMPOSE)
  `CKL_ASSERT_IMP(a_beat_follows_read, result_valid, $past(start && !busy && cmd.op == OP_READ))
  `CKL_ASSERT_NEVER(a_clear_writes_both, busy && !(wr.color_we && wr.depth_we))

endmodule
